// ===== hw/rtl/otsu_pkg.sv =====
// Shared constants and types for the Otsu threshold block.
package otsu_pkg;

  localparam int GRAY_LEVELS = 256;
  localparam int BIN_AW      = $clog2(GRAY_LEVELS);
  localparam int PIX_W       = 8;
  localparam int CNT_W       = 24;
  localparam int SUM_W       = 32;

  localparam longint unsigned MAX_PIXELS = 64'd16777215;
  localparam longint unsigned COUNT_FULL = (64'd1 << CNT_W) - 64'd1;
  localparam logic [CNT_W-1:0] COUNT_CAP =
      CNT_W'((MAX_PIXELS < COUNT_FULL) ? MAX_PIXELS : COUNT_FULL);

  // |N*s - T*c| < 2^56, c*(N-c) < 2^46, products stay below 2^158
  localparam int D_W     = 56;
  localparam int DEN_W   = 48;
  localparam int D2_W    = 2 * D_W;
  localparam int MUL_A_W = D2_W;
  localparam int MUL_B_W = D_W;
  localparam int PROD_W  = 160;

  localparam logic [BIN_AW-1:0] LAST_CAND = BIN_AW'(GRAY_LEVELS - 2);

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic              en;
    logic [BIN_AW-1:0] bin;
  } acc_req_t;

endpackage

// ===== hw/rtl/otsu_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module otsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/otsu_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle, stops early on zero.
module otsu_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  otsu_pkg::mul_req_t req_i,
  output otsu_pkg::mul_rsp_t rsp_o
);
  import otsu_pkg::*;

  logic               busy_q, busy_d;
  logic [PROD_W-1:0]  acc_q, acc_d;
  logic [PROD_W-1:0]  mcand_q, mcand_d;
  logic [MUL_B_W-1:0] mplier_q, mplier_d;

  always_comb begin
    busy_d   = busy_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    if (req_i.start) begin
      busy_d   = 1'b1;
      acc_d    = '0;
      mcand_d  = PROD_W'(req_i.a);
      mplier_d = req_i.b;
    end else if (busy_q) begin
      if (mplier_q == '0) begin
        busy_d = 1'b0;
      end else begin
        if (mplier_q[0]) begin
          acc_d = acc_q + mcand_q;
        end
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign rsp_o.done = busy_q && (mplier_q == '0);
  assign rsp_o.prod = acc_q;

endmodule

// ===== hw/rtl/otsu_hist.sv =====
// Histogram store: bin RAM with per-bin valid bits and read-modify-write increment.
module otsu_hist (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  otsu_pkg::acc_req_t          acc_i,
  input  logic                        clear_i,
  input  logic [otsu_pkg::BIN_AW-1:0] scan_addr_i,
  output logic [otsu_pkg::CNT_W-1:0]  scan_cnt_o
);
  import otsu_pkg::*;

  logic [GRAY_LEVELS-1:0] valid_q;
  logic                   vld_rd_q;
  logic                   s1_vld_q;
  logic [BIN_AW-1:0]      s1_addr_q;
  logic                   wb_vld_q;
  logic [BIN_AW-1:0]      wb_addr_q;
  logic [CNT_W-1:0]       wb_data_q;

  logic [BIN_AW-1:0] raddr;
  logic [CNT_W-1:0]  rdata;
  logic [CNT_W-1:0]  stored;
  logic [CNT_W-1:0]  old_cnt;
  logic [CNT_W-1:0]  new_cnt;

  assign raddr   = acc_i.en ? acc_i.bin : scan_addr_i;
  assign stored  = vld_rd_q ? rdata : '0;
  // forward the write of the previous beat if it hit the same bin
  assign old_cnt = (wb_vld_q && (wb_addr_q == s1_addr_q)) ? wb_data_q : stored;
  assign new_cnt = old_cnt + CNT_W'(1);

  otsu_ram #(
    .WIDTH(CNT_W),
    .DEPTH(GRAY_LEVELS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (s1_vld_q),
    .waddr_i(s1_addr_q),
    .wdata_i(new_cnt),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      vld_rd_q <= 1'b0;
      s1_vld_q <= 1'b0;
      wb_vld_q <= 1'b0;
    end else begin
      vld_rd_q <= valid_q[raddr];
      s1_vld_q <= acc_i.en;
      wb_vld_q <= s1_vld_q;
      if (clear_i) begin
        valid_q <= '0;
      end else if (s1_vld_q) begin
        valid_q[s1_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= acc_i.bin;
    wb_addr_q <= s1_addr_q;
    wb_data_q <= new_cnt;
  end

  assign scan_cnt_o = stored;

endmodule

// ===== hw/rtl/otsu_scan.sv =====
// Threshold sweep: walks the bins, scores candidates, keeps the best by cross-multiplication.
module otsu_scan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        go_i,
  input  logic [otsu_pkg::CNT_W-1:0]  n_i,
  input  logic [otsu_pkg::SUM_W-1:0]  tot_i,
  output logic [otsu_pkg::BIN_AW-1:0] rd_addr_o,
  input  logic [otsu_pkg::CNT_W-1:0]  rd_cnt_i,
  output logic                        done_o,
  output logic [otsu_pkg::BIN_AW-1:0] thr_o
);
  import otsu_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_BIN  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  localparam logic [2:0] STEP_NS  = 3'd0;
  localparam logic [2:0] STEP_TC  = 3'd1;
  localparam logic [2:0] STEP_DEN = 3'd2;
  localparam logic [2:0] STEP_D2  = 3'd3;
  localparam logic [2:0] STEP_LHS = 3'd4;
  localparam logic [2:0] STEP_RHS = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [2:0]        mstep_q, mstep_d;
  logic              mstart_q, mstart_d;
  logic [BIN_AW-1:0] idx_q, idx_d;
  logic [CNT_W-1:0]  c_q, c_d;
  logic [SUM_W-1:0]  s_q, s_d;
  logic [D_W-1:0]    ns_q, ns_d;
  logic [D_W-1:0]    d_q, d_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [D2_W-1:0]   d2_q, d2_d;
  logic [PROD_W-1:0] lhs_q, lhs_d;
  logic [D2_W-1:0]   best_d2_q, best_d2_d;
  logic [DEN_W-1:0]  best_den_q, best_den_d;
  logic [BIN_AW-1:0] best_t_q, best_t_d;

  mul_req_t         mreq;
  mul_rsp_t         mrsp;
  logic [D_W-1:0]   tc;
  logic [D_W-1:0]   diff;
  logic             adv;

  otsu_mul u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mreq),
    .rsp_o (mrsp)
  );

  assign tc   = mrsp.prod[D_W-1:0];
  assign diff = (ns_q >= tc) ? (ns_q - tc) : (tc - ns_q);

  always_comb begin
    mreq.start = mstart_q;
    mreq.a     = '0;
    mreq.b     = '0;
    unique case (mstep_q)
      STEP_NS: begin
        mreq.a = MUL_A_W'(s_q);
        mreq.b = MUL_B_W'(n_i);
      end
      STEP_TC: begin
        mreq.a = MUL_A_W'(tot_i);
        mreq.b = MUL_B_W'(c_q);
      end
      STEP_DEN: begin
        mreq.a = MUL_A_W'(c_q);
        mreq.b = MUL_B_W'(n_i - c_q);
      end
      STEP_D2: begin
        mreq.a = MUL_A_W'(d_q);
        mreq.b = d_q;
      end
      STEP_LHS: begin
        mreq.a = d2_q;
        mreq.b = MUL_B_W'(best_den_q);
      end
      STEP_RHS: begin
        mreq.a = best_d2_q;
        mreq.b = MUL_B_W'(den_q);
      end
      default: begin
        mreq.a = '0;
        mreq.b = '0;
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    mstep_d    = mstep_q;
    mstart_d   = 1'b0;
    idx_d      = idx_q;
    c_d        = c_q;
    s_d        = s_q;
    ns_d       = ns_q;
    d_d        = d_q;
    den_d      = den_q;
    d2_d       = d2_q;
    lhs_d      = lhs_q;
    best_d2_d  = best_d2_q;
    best_den_d = best_den_q;
    best_t_d   = best_t_q;
    adv        = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (go_i) begin
          idx_d      = '0;
          c_d        = '0;
          s_d        = '0;
          best_d2_d  = '0;
          best_den_d = DEN_W'(1);
          best_t_d   = '0;
          state_d    = S_RD;
        end
      end
      S_RD: begin
        state_d = S_BIN;
      end
      S_BIN: begin
        // empty bin repeats the previous score and cannot win
        if (rd_cnt_i == '0) begin
          adv = 1'b1;
        end else begin
          c_d     = c_q + rd_cnt_i;
          s_d     = s_q + SUM_W'(idx_q) * SUM_W'(rd_cnt_i);
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        // full class: this and every later candidate score zero
        if (c_q >= n_i) begin
          state_d = S_FIN;
        end else begin
          mstep_d  = STEP_NS;
          mstart_d = 1'b1;
          state_d  = S_MUL;
        end
      end
      S_MUL: begin
        if (mrsp.done) begin
          unique case (mstep_q)
            STEP_NS: begin
              ns_d     = mrsp.prod[D_W-1:0];
              mstep_d  = STEP_TC;
              mstart_d = 1'b1;
            end
            STEP_TC: begin
              if (diff == '0) begin
                adv = 1'b1;
              end else begin
                d_d      = diff;
                mstep_d  = STEP_DEN;
                mstart_d = 1'b1;
              end
            end
            STEP_DEN: begin
              den_d    = mrsp.prod[DEN_W-1:0];
              mstep_d  = STEP_D2;
              mstart_d = 1'b1;
            end
            STEP_D2: begin
              d2_d     = mrsp.prod[D2_W-1:0];
              mstep_d  = STEP_LHS;
              mstart_d = 1'b1;
            end
            STEP_LHS: begin
              lhs_d    = mrsp.prod;
              mstep_d  = STEP_RHS;
              mstart_d = 1'b1;
            end
            STEP_RHS: begin
              if (lhs_q > mrsp.prod) begin
                best_d2_d  = d2_q;
                best_den_d = den_q;
                best_t_d   = idx_q;
              end
              adv = 1'b1;
            end
            default: begin
              adv = 1'b1;
            end
          endcase
        end
      end
      S_FIN: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (adv) begin
      if (idx_q == LAST_CAND) begin
        state_d = S_FIN;
      end else begin
        idx_d   = idx_q + BIN_AW'(1);
        state_d = S_RD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mstep_q  <= STEP_NS;
      mstart_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mstep_q  <= mstep_d;
      mstart_q <= mstart_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    c_q        <= c_d;
    s_q        <= s_d;
    ns_q       <= ns_d;
    d_q        <= d_d;
    den_q      <= den_d;
    d2_q       <= d2_d;
    lhs_q      <= lhs_d;
    best_d2_q  <= best_d2_d;
    best_den_q <= best_den_d;
    best_t_q   <= best_t_d;
  end

  assign rd_addr_o = idx_q;
  assign done_o    = (state_q == S_FIN);
  assign thr_o     = best_t_q;

endmodule

// ===== hw/rtl/otsu_threshold.sv =====
// Otsu threshold top level: pixel intake, frame counters and result strobe.
//
// Pixels are taken one per cycle (start high, busy low) and binned into a
// 256-entry histogram RAM through a read-modify-write pipeline with
// forwarding. Accepting the pixel flagged last_pixel_i raises busy; the block
// then sweeps the bins and, when done, presents threshold_o and
// frame_too_long_o for exactly one cycle with done_o high. That beat cannot
// be held off, so capture it when it appears. The sweep skips empty bins and,
// for each occupied bin below the point where every pixel has been counted,
// runs up to six products on the serial shift-add multiplier, stopping after
// the second when the class difference is zero; each product works through
// its multiplier operand bit by bit (at most 24, 24, 24, 56, 46 and 46 bits).
// busy falls the cycle after done_o and the histogram is already
// empty then; per-bin valid bits clear it at once, with no clearing pass.
// Pixels beyond the count cap are dropped and reported by frame_too_long_o.
module otsu_threshold (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic [otsu_pkg::PIX_W-1:0]  pixel_i,
  input  logic                        last_pixel_i,
  output logic                        busy,
  output logic                        done_o,
  output logic [otsu_pkg::PIX_W-1:0]  threshold_o,
  output logic                        frame_too_long_o
);
  import otsu_pkg::*;

  logic             busy_q;
  logic             go_q;
  logic [CNT_W-1:0] total_q;
  logic [SUM_W-1:0] sum_q;
  logic             ovf_q;

  logic              accept;
  logic              bin_en;
  logic              scan_done;
  logic [BIN_AW-1:0] scan_addr;
  logic [CNT_W-1:0]  scan_cnt;
  logic [BIN_AW-1:0] thr;
  acc_req_t          acc;

  assign accept  = start && !busy_q;
  assign bin_en  = accept && (total_q < COUNT_CAP);
  assign acc.en  = bin_en;
  assign acc.bin = pixel_i[BIN_AW-1:0];

  otsu_hist u_hist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .clear_i    (scan_done),
    .scan_addr_i(scan_addr),
    .scan_cnt_o (scan_cnt)
  );

  otsu_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (go_q),
    .n_i      (total_q),
    .tot_i    (sum_q),
    .rd_addr_o(scan_addr),
    .rd_cnt_i (scan_cnt),
    .done_o   (scan_done),
    .thr_o    (thr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      go_q    <= 1'b0;
      total_q <= '0;
      sum_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      // go is registered so the last pixel's write lands before the sweep reads
      go_q <= accept && last_pixel_i;
      if (scan_done) begin
        busy_q  <= 1'b0;
        total_q <= '0;
        sum_q   <= '0;
        ovf_q   <= 1'b0;
      end else begin
        if (bin_en) begin
          total_q <= total_q + CNT_W'(1);
          sum_q   <= sum_q + SUM_W'(pixel_i);
        end else if (accept) begin
          ovf_q <= 1'b1;
        end
        if (accept && last_pixel_i) begin
          busy_q <= 1'b1;
        end
      end
    end
  end

  assign busy             = busy_q;
  assign done_o           = scan_done;
  assign threshold_o      = PIX_W'(thr);
  assign frame_too_long_o = ovf_q;

endmodule

// ===== hw/rtl/otsu_chk.sv =====
// Port-level assertions for the Otsu threshold block, bound to the top level.
module otsu_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic last_pixel_i,
  input logic busy,
  input logic done_o
);

  a_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result beat outside a busy period");

  a_release_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("busy held after the result beat");

  a_busy_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && last_pixel_i))
    else $error("busy rose without a last pixel");

  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result beat longer than one cycle");

endmodule

bind otsu_threshold otsu_chk u_otsu_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .last_pixel_i(last_pixel_i),
  .busy        (busy),
  .done_o      (done_o)
);
